// ===== rtl/robin_hood_hash_set_assert.svh =====
// assertion macros for the hash set checker
`ifndef ROBIN_HOOD_HASH_SET_ASSERT_SVH
`define ROBIN_HOOD_HASH_SET_ASSERT_SVH

// same-cycle implication
`define RHS_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("rhs assertion failed");

// next-cycle implication
`define RHS_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("rhs assertion failed");

`endif

// ===== rtl/rhs_pkg.sv =====
`timescale 1ns / 1ps
package rhs_pkg;

  localparam int KEY_W     = 64;
  localparam int LEN_W     = 4;
  localparam int HASH_W    = 32;
  localparam int DIST_W    = 6;
  localparam int STAT_W    = 3;
  localparam int CNT_W     = 11;
  localparam int CMD_W     = 2;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT    = 3'd3;
  localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd4;
  localparam logic [STAT_W-1:0] ST_LOAD_FULL = 3'd5;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_ADD, S_FIND, S_SHIFT_READ, S_SHIFT, S_SHIFT_END, S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_ACCEPT, OP_READ, OP_ADD, OP_FIND,
    OP_SHIFT_READ, OP_SHIFT, OP_SHIFT_END, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   in_ready;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic in_valid;
    logic early;
    logic is_add;
    logic is_remove;
    logic add_end;
    logic found;
    logic miss_end;
    logic shift_stop;
    logic bound;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/rhs_if.sv =====
`timescale 1ns / 1ps
interface rhs_req_if import rhs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [KEY_W-1:0]  key;
  logic [LEN_W-1:0]  key_len;
  logic [HASH_W-1:0] key_hash;
  modport source (output valid, cmd, key, key_len, key_hash, input ready);
  modport sink (input valid, cmd, key, key_len, key_hash, output ready);
endinterface

interface rhs_resp_if import rhs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  entry_total;
  logic [KEY_W-1:0]  carried_key;
  logic [LEN_W-1:0]  carried_len;
  logic [HASH_W-1:0] carried_hash;
  modport source (output valid, status, entry_total, carried_key, carried_len, carried_hash,
                  input ready);
  modport sink (input valid, status, entry_total, carried_key, carried_len, carried_hash,
                output ready);
endinterface

// ===== rtl/robin_hood_hash_set.sv =====
`timescale 1ns / 1ps
// channel  | dir | handshake     | payload
// req      | in  | valid / ready | cmd, key, key_len, key_hash
// resp     | out | valid / ready | status, entry_total, carried_key, carried_len, carried_hash
// cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// one request at a time; each probe step is a slot read state plus an evaluate state,
// add or find; a remove then steps through shift read and shift states over the
// shifted slots, plus a shift end state when the shift walks all slots; load full
// and the unused command go from idle straight to the finish state
// after reset the ram is swept empty, with req.ready low
// a stalled resp keeps the walk in the finish state, with req.ready low
module robin_hood_hash_set import rhs_pkg::*; #(
  parameter int SLOTS    = 1024,
  parameter int KEY_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  rhs_req_if.sink              req,
  rhs_resp_if.source           resp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);
  ctl_t  ctl;
  stat_t st;

  rhs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .st(st), .ctl(ctl)
  );

  rhs_datapath #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_datapath (
    .clk(clk), .rst(rst), .req(req), .resp(resp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .ctl(ctl), .st(st)
  );
endmodule

// ===== rtl/rhs_ram.sv =====
`timescale 1ns / 1ps
module rhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/rhs_ctrl.sv =====
`timescale 1ns / 1ps
module rhs_ctrl import rhs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t st,
  output ctl_t  ctl
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (st.in_valid) state_next = st.early ? S_FINISH : S_READ;
      end
      S_READ: begin
        state_next = st.is_add ? S_ADD : S_FIND;
      end
      S_ADD: begin
        state_next = st.add_end ? S_FINISH : S_READ;
      end
      S_FIND: begin
        if (st.found) state_next = st.is_remove ? S_SHIFT_READ : S_FINISH;
        else if (st.miss_end) state_next = S_FINISH;
        else state_next = S_READ;
      end
      S_SHIFT_READ: begin
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (st.shift_stop) state_next = S_FINISH;
        else if (st.bound) state_next = S_SHIFT_END;
        else state_next = S_SHIFT_READ;
      end
      S_SHIFT_END: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    ctl.in_ready = 1'b0;
    case (state)
      S_CLEAR:      ctl.op = OP_CLEAR;
      S_IDLE: begin
        ctl.op = OP_ACCEPT;
        ctl.in_ready = 1'b1;
      end
      S_READ:       ctl.op = OP_READ;
      S_ADD:        ctl.op = OP_ADD;
      S_FIND:       ctl.op = OP_FIND;
      S_SHIFT_READ: ctl.op = OP_SHIFT_READ;
      S_SHIFT:      ctl.op = OP_SHIFT;
      S_SHIFT_END:  ctl.op = OP_SHIFT_END;
      S_FINISH:     ctl.op = OP_FINISH;
      default:      ctl.op = OP_NONE;
    endcase
  end
endmodule

// ===== rtl/rhs_datapath.sv =====
`timescale 1ns / 1ps
module rhs_datapath import rhs_pkg::*; #(
  parameter int SLOTS    = 1024,
  parameter int KEY_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  rhs_req_if.sink              req,
  rhs_resp_if.source           resp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  ctl_t                 ctl,
  output stat_t                st
);
  localparam int AW   = $clog2(SLOTS);
  localparam int CW   = AW + 1;
  localparam int D_LO = 1;
  localparam int L_LO = D_LO + DIST_W;
  localparam int H_LO = L_LO + LEN_W;
  localparam int K_LO = H_LO + HASH_W;
  localparam int SW   = K_LO + KEY_BITS;

  logic [DIST_W-1:0]   probe_limit;
  logic [CNT_W-1:0]    load_limit;
  logic [CNT_W-1:0]    count;
  logic [AW-1:0]       clr_cnt;
  logic [CMD_W-1:0]    cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [LEN_W-1:0]    len_r;
  logic [HASH_W-1:0]   hash_r;
  logic [KEY_BITS-1:0] h_key;
  logic [LEN_W-1:0]    h_len;
  logic [HASH_W-1:0]   h_hash;
  logic [DIST_W-1:0]   h_dist;
  logic                swapped;
  logic [AW-1:0]       idx;
  logic [CW-1:0]       n;
  logic [STAT_W-1:0]   res_status;
  logic [KEY_BITS-1:0] car_key;
  logic [LEN_W-1:0]    car_len;
  logic [HASH_W-1:0]   car_hash;
  logic                out_valid;

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [SW-1:0]       wdata, rdata;

  logic [KEY_W-1:0]    kmask;
  logic [KEY_BITS-1:0] nkey;
  logic                full;

  logic                s_used, s_match, swap, limit_hit, bound, miss, shift_stop, dup, out_free;
  logic [DIST_W-1:0]   s_dist;
  logic [LEN_W-1:0]    s_len;
  logic [HASH_W-1:0]   s_hash;
  logic [KEY_BITS-1:0] s_key;
  logic [DIST_W:0]     new_dist;
  logic [SW-1:0]       h_word, shift_word;

  rhs_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // key normalization by byte length
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      kmask[b*8 +: 8] = {8{req.key_len > LEN_W'(b)}};
    end
  end
  assign nkey = KEY_BITS'(req.key & kmask);
  assign full = count >= load_limit;

  assign s_used  = rdata[0];
  assign s_dist  = rdata[D_LO +: DIST_W];
  assign s_len   = rdata[L_LO +: LEN_W];
  assign s_hash  = rdata[H_LO +: HASH_W];
  assign s_key   = rdata[K_LO +: KEY_BITS];
  assign s_match = s_used && s_hash == hash_r && s_len == len_r && s_key == key_r;
  assign dup     = !swapped && s_match;
  assign swap    = h_dist > s_dist;
  assign new_dist  = {1'b0, (swap ? s_dist : h_dist)} + (DIST_W+1)'(1);
  assign limit_hit = new_dist >= {1'b0, probe_limit};
  assign bound     = n == CW'(SLOTS - 1);
  assign miss      = !s_used || (32'(n) > 32'(s_dist));
  assign shift_stop = !s_used || s_dist == '0;
  assign out_free  = !out_valid || resp.ready;

  assign h_word     = {h_key, h_hash, h_len, h_dist, 1'b1};
  assign shift_word = {s_key, s_hash, s_len, s_dist - DIST_W'(1), 1'b1};

  assign st.clr_last   = clr_cnt == AW'(SLOTS - 1);
  assign st.in_valid   = req.valid;
  assign st.early      = (req.cmd == CMD_ADD && full) || req.cmd == CMD_UNUSED;
  assign st.is_add     = cmd_r == CMD_ADD;
  assign st.is_remove  = cmd_r == CMD_REMOVE;
  assign st.add_end    = !s_used || dup || limit_hit || bound;
  assign st.found      = s_match;
  assign st.miss_end   = miss || bound;
  assign st.shift_stop = shift_stop;
  assign st.bound      = bound;
  assign st.out_free   = out_free;

  assign req.ready = ctl.in_ready;
  assign raddr = (ctl.op == OP_SHIFT_READ) ? idx + AW'(1) : idx;

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = '0;
    case (ctl.op)
      OP_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
      end
      OP_ADD: begin
        wdata = h_word;
        we    = !s_used || (!dup && swap);
      end
      OP_SHIFT: begin
        we    = 1'b1;
        wdata = shift_stop ? '0 : shift_word;
      end
      OP_SHIFT_END: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_limit <= DIST_W'(10);
      load_limit  <= CNT_W'(921);
      count       <= '0;
      clr_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_PROBE_LIMIT) probe_limit <= cfg_data[DIST_W-1:0];
      if (cfg_we && cfg_index == CFG_LOAD_LIMIT) load_limit <= cfg_data;
      if (ctl.op == OP_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (ctl.op == OP_ADD && !s_used) count <= count + CNT_W'(1);
      if (ctl.op == OP_FIND && s_match && cmd_r == CMD_REMOVE) count <= count - CNT_W'(1);
      if (out_valid && resp.ready) out_valid <= 1'b0;
      if (ctl.op == OP_FINISH && out_free) out_valid <= 1'b1;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_ACCEPT: begin
        if (req.valid) begin
          cmd_r    <= req.cmd;
          key_r    <= nkey;
          len_r    <= req.key_len;
          hash_r   <= req.key_hash;
          h_key    <= nkey;
          h_len    <= req.key_len;
          h_hash   <= req.key_hash;
          h_dist   <= '0;
          swapped  <= 1'b0;
          idx      <= req.key_hash[AW-1:0];
          n        <= '0;
          res_status <= (req.cmd == CMD_ADD && full) ? ST_LOAD_FULL : ST_ABSENT;
          car_key  <= '0;
          car_len  <= '0;
          car_hash <= '0;
        end
      end
      OP_ADD: begin
        if (!s_used) begin
          res_status <= ST_INSERTED;
        end else if (dup) begin
          res_status <= ST_DUPLICATE;
        end else begin
          if (swap) begin
            h_key   <= s_key;
            h_len   <= s_len;
            h_hash  <= s_hash;
            swapped <= 1'b1;
          end
          h_dist <= new_dist[DIST_W-1:0];
          idx    <= idx + AW'(1);
          n      <= n + CW'(1);
          if (limit_hit || bound) begin
            res_status <= ST_OVERFLOW;
            car_key    <= swap ? s_key : h_key;
            car_len    <= swap ? s_len : h_len;
            car_hash   <= swap ? s_hash : h_hash;
          end
        end
      end
      OP_FIND: begin
        if (s_match) begin
          res_status <= (cmd_r == CMD_CONTAINS) ? ST_PRESENT : ST_REMOVED;
          n <= '0;
        end else if (!miss) begin
          idx <= idx + AW'(1);
          n   <= n + CW'(1);
        end
      end
      OP_SHIFT: begin
        if (!shift_stop) begin
          idx <= idx + AW'(1);
          n   <= n + CW'(1);
        end
      end
      OP_FINISH: begin
        if (out_free) begin
          resp.status       <= res_status;
          resp.entry_total  <= count;
          resp.carried_key  <= KEY_W'(car_key);
          resp.carried_len  <= car_len;
          resp.carried_hash <= car_hash;
        end
      end
      default: begin
      end
    endcase
  end

  assign resp.valid = out_valid;
endmodule

// ===== rtl/rhs_check.sv =====
`timescale 1ns / 1ps
`include "robin_hood_hash_set_assert.svh"
module rhs_check import rhs_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              resp_valid,
  input logic              resp_ready,
  input logic [STAT_W-1:0] status,
  input logic [LEN_W-1:0]  carried_len,
  input logic [HASH_W-1:0] carried_hash
);
  `RHS_ASSERT_NEXT(a_resp_hold, clk, rst, resp_valid && !resp_ready, resp_valid)
  `RHS_ASSERT_IMPL(a_status_code, clk, rst, resp_valid, status <= ST_OVERFLOW)
  `RHS_ASSERT_IMPL(a_carry_zero, clk, rst, resp_valid && status != ST_OVERFLOW, carried_len == '0 && carried_hash == '0)
endmodule

bind robin_hood_hash_set rhs_check u_rhs_check (
  .clk(clk), .rst(rst), .resp_valid(resp.valid), .resp_ready(resp.ready),
  .status(resp.status), .carried_len(resp.carried_len), .carried_hash(resp.carried_hash)
);
